[rtl/pfld_pkg.sv]
// ----------------------------------------------------------------------------
// pfld_pkg
// Shared types and codes of the lake depth flood block.
// ----------------------------------------------------------------------------
package pfld_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_FILL  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] ST_DEPTH = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  localparam logic signed [1:0] NB_DX [8] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0,
                                             -2'sd1, 2'sd1, -2'sd1, 2'sd1};
  localparam logic signed [1:0] NB_DY [8] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1,
                                             -2'sd1, -2'sd1, 2'sd1, 2'sd1};

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_SW_RD,
    S_SW_PUSH,
    S_SW_ADV,
    S_SU_CHK,
    S_SU_CMP,
    S_POP,
    S_POP_TOP,
    S_POP_LAST,
    S_SD_L,
    S_SD_R,
    S_SD_CMP,
    S_NB_CHK,
    S_NB_TST,
    S_NB_ADV
  } state_t;

endpackage

[rtl/pfld_ram.sv]
// ----------------------------------------------------------------------------
// pfld_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/priority_flood_lake_depth.sv]
// ----------------------------------------------------------------------------
// priority_flood_lake_depth
// Lake depth over a square height grid by an 8-neighbour priority flood.
// ----------------------------------------------------------------------------
// Input words (s_*) carry a mode in tuser: write a cell height, run a fill,
// or read the water depth of a cell. Result words (m_*) carry the depth in
// tdata and a status in tuser. The cfg channel sets the grid side.
// A write gives no result. A read enters the S_RD state, which registers its
// result from the RAM read data; a bad index or no fill yet gives an error
// result in the cycle after it is accepted. A fill sweeps every cell of the
// grid once, which sets the visit mark of each border cell, clears the others
// and pushes each border cell, then runs the heap flood: each pop takes the
// top, moves the last entry to the root and sifts it down level by level, each
// push sifts up level by level, and each pop checks its eight neighbours, with
// one RAM read port per memory. The fill result arrives when the heap is
// empty.
// One word is in work at a time; s_tready is low while a word is in work or
// a result waits on m_tready, so a stalled receiver holds the input channel.
// Reset clears control state and sets the grid side to 256; cell heights
// are undefined until written.
// ----------------------------------------------------------------------------
module priority_flood_lake_depth
  import pfld_pkg::*;
#(
  parameter int MAX_SIDE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // cell_index[15:0], bedrock[47:16], sediment[79:48]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // water_depth[31:0]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);

  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int NW    = 2 * SW;
  localparam int HW    = 32 + 2 * XW;

  function automatic logic hless(input logic [HW-1:0] a, input logic [HW-1:0] b);
    logic signed [31:0] ka;
    logic signed [31:0] kb;
    ka = a[HW-1 -: 32];
    kb = b[HW-1 -: 32];
    return (ka < kb) || ((ka == kb) && (a[2*XW-1:0] < b[2*XW-1:0]));
  endfunction

  state_t state, state_next, ret, ret_next;

  logic [8:0]    grid_side, grid_side_next;
  logic          fill_valid, fill_valid_next;
  logic          out_valid, out_valid_next;
  logic [31:0]   out_depth, out_depth_next;
  logic [1:0]    out_status, out_status_next;
  logic [AW:0]   cnt, cnt_next;
  logic [AW-1:0] addr, addr_next;
  logic [XW-1:0] x, x_next, y, y_next;
  logic [XW-1:0] cx, cx_next, cy, cy_next;
  logic [XW-1:0] nx, nx_next, ny, ny_next;
  logic [AW-1:0] ni, ni_next;
  logic [31:0]   lvl, lvl_next;
  logic [2:0]    k, k_next;
  logic [AW-1:0] p, p_next, par, par_next;
  logic [HW-1:0] ent, ent_next, ecl, ecl_next;
  logic          has_r, has_r_next;

  logic          g_we, f_we, v_we, h_we;
  logic [AW-1:0] g_wa, f_wa, v_wa, h_wa;
  logic [AW-1:0] g_ra, f_ra, v_ra, h_ra;
  logic [31:0]   g_wd, f_wd, g_rd, f_rd;
  logic          v_wd, v_rd;
  logic [HW-1:0] h_wd, h_rd;

  pfld_ram #(.WIDTH(32), .DEPTH(CELLS)) u_ground (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
  );
  pfld_ram #(.WIDTH(32), .DEPTH(CELLS)) u_fill (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
  );
  pfld_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );
  pfld_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
  );

  logic [1:0]         mode;
  logic [15:0]        cell_index;
  logic [31:0]        bedrock, sediment, sat;
  logic signed [32:0] sum, diff;
  logic [SW-1:0]      side_use;
  logic [XW-1:0]      side_m1;
  logic [NW-1:0]      cell_cnt;
  logic               idx_ok, in_acc, border, last_cell, nvalid, nb_less, up_less;
  logic [AW:0]        l_idx, r_idx;
  logic [AW-1:0]      best_i;
  logic [HW-1:0]      best_d;
  logic [XW-1:0]      nx_c, ny_c;
  logic [AW-1:0]      ni_c;
  logic [31:0]        new_lvl;

  assign mode       = s_tuser;
  assign cell_index = s_tdata[15:0];
  assign bedrock    = s_tdata[47:16];
  assign sediment   = s_tdata[79:48];

  assign s_tready  = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_depth;
  assign m_tuser   = out_status;
  assign in_acc    = s_tvalid && s_tready;

  always_comb begin
    if (32'(grid_side) < 32'd2) begin
      side_use = SW'(2);
    end else if (32'(grid_side) > 32'(MAX_SIDE)) begin
      side_use = SW'(MAX_SIDE);
    end else begin
      side_use = SW'(grid_side);
    end
    side_m1  = XW'(side_use - SW'(1));
    cell_cnt = NW'(side_use) * NW'(side_use);
    idx_ok   = 32'(cell_index) < 32'(cell_cnt);
    sum      = {bedrock[31], bedrock} + {sediment[31], sediment};
    if (sum[32] != sum[31]) begin
      sat = sum[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat = sum[31:0];
    end
    diff = {f_rd[31], f_rd} - {g_rd[31], g_rd};

    border    = (x == '0) || (y == '0) || (x == side_m1) || (y == side_m1);
    last_cell = (x == side_m1) && (y == side_m1);

    l_idx = {p, 1'b1};
    r_idx = l_idx + (AW+1)'(1);
    if (has_r && hless(h_rd, ecl)) begin
      best_d = h_rd;
      best_i = r_idx[AW-1:0];
    end else begin
      best_d = ecl;
      best_i = l_idx[AW-1:0];
    end
    nb_less = hless(best_d, ent);
    up_less = hless(ent, h_rd);

    nvalid = 1'b1;
    nx_c   = cx;
    ny_c   = cy;
    if (NB_DX[k] < 0) begin
      nvalid = nvalid && (cx != '0);
      nx_c   = cx - XW'(1);
    end else if (NB_DX[k] > 0) begin
      nvalid = nvalid && (cx != side_m1);
      nx_c   = cx + XW'(1);
    end
    if (NB_DY[k] < 0) begin
      nvalid = nvalid && (cy != '0);
      ny_c   = cy - XW'(1);
    end else if (NB_DY[k] > 0) begin
      nvalid = nvalid && (cy != side_m1);
      ny_c   = cy + XW'(1);
    end
    ni_c = AW'(NW'(ny_c) * NW'(side_use) + NW'(nx_c));
    new_lvl = ($signed(g_rd) > $signed(lvl)) ? g_rd : lvl;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (mode == MODE_FILL) begin
            state_next = S_SW_RD;
          end else if (mode == MODE_READ && idx_ok && fill_valid) begin
            state_next = S_RD;
          end
        end
      end
      S_RD:       state_next = S_IDLE;
      S_SW_RD:    state_next = border ? S_SW_PUSH : S_SW_ADV;
      S_SW_PUSH:  state_next = S_SU_CHK;
      S_SW_ADV:   state_next = last_cell ? S_POP : S_SW_RD;
      S_SU_CHK:   state_next = (p == '0) ? ret : S_SU_CMP;
      S_SU_CMP:   state_next = up_less ? S_SU_CHK : ret;
      S_POP:      state_next = (cnt == '0) ? S_IDLE : S_POP_TOP;
      S_POP_TOP:  state_next = (cnt == (AW+1)'(1)) ? S_NB_CHK : S_POP_LAST;
      S_POP_LAST: state_next = S_SD_L;
      S_SD_L:     state_next = (l_idx >= cnt) ? S_NB_CHK : S_SD_R;
      S_SD_R:     state_next = S_SD_CMP;
      S_SD_CMP:   state_next = nb_less ? S_SD_L : S_NB_CHK;
      S_NB_CHK:   state_next = nvalid ? S_NB_TST : S_NB_ADV;
      S_NB_TST:   state_next = v_rd ? S_NB_ADV : S_SU_CHK;
      S_NB_ADV:   state_next = (k == 3'd7) ? S_POP : S_NB_CHK;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    grid_side_next  = grid_side;
    fill_valid_next = fill_valid;
    out_valid_next  = out_valid;
    out_depth_next  = out_depth;
    out_status_next = out_status;
    cnt_next = cnt;
    addr_next = addr;
    x_next = x;
    y_next = y;
    cx_next = cx;
    cy_next = cy;
    nx_next = nx;
    ny_next = ny;
    ni_next = ni;
    lvl_next = lvl;
    k_next = k;
    p_next = p;
    par_next = par;
    ent_next = ent;
    ecl_next = ecl;
    has_r_next = has_r;
    ret_next = ret;
    g_we = 1'b0; g_wa = '0; g_wd = sat; g_ra = '0;
    f_we = 1'b0; f_wa = '0; f_wd = g_rd; f_ra = '0;
    v_we = 1'b0; v_wa = '0; v_wd = 1'b0; v_ra = '0;
    h_we = 1'b0; h_wa = p;  h_wd = ent;  h_ra = '0;

    if (m_tvalid && m_tready) begin
      out_valid_next = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      grid_side_next  = cfg_data;
      fill_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (mode)
            MODE_WRITE: begin
              if (idx_ok) begin
                g_we = 1'b1;
                g_wa = AW'(cell_index);
                fill_valid_next = 1'b0;
              end
            end
            MODE_FILL: begin
              cnt_next  = '0;
              addr_next = '0;
              x_next    = '0;
              y_next    = '0;
            end
            MODE_READ: begin
              g_ra = AW'(cell_index);
              f_ra = AW'(cell_index);
              if (!idx_ok || !fill_valid) begin
                out_valid_next  = 1'b1;
                out_depth_next  = '0;
                out_status_next = ST_ERR;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        out_valid_next  = 1'b1;
        out_depth_next  = diff[32] ? 32'd0 : diff[31:0];
        out_status_next = ST_DEPTH;
      end
      S_SW_RD: begin
        g_ra = addr;
        v_we = 1'b1;
        v_wa = addr;
        v_wd = border;
      end
      S_SW_PUSH: begin
        f_we     = 1'b1;
        f_wa     = addr;
        ent_next = {g_rd, y, x};
        p_next   = cnt[AW-1:0];
        cnt_next = cnt + (AW+1)'(1);
        ret_next = S_SW_ADV;
      end
      S_SW_ADV: begin
        if (!last_cell) begin
          addr_next = addr + AW'(1);
          if (x == side_m1) begin
            x_next = '0;
            y_next = y + XW'(1);
          end else begin
            x_next = x + XW'(1);
          end
        end
      end
      S_SU_CHK: begin
        if (p == '0) begin
          h_we = 1'b1;
        end else begin
          h_ra     = (p - AW'(1)) >> 1;
          par_next = (p - AW'(1)) >> 1;
        end
      end
      S_SU_CMP: begin
        h_we = 1'b1;
        if (up_less) begin
          h_wd   = h_rd;
          p_next = par;
        end
      end
      S_POP: begin
        if (cnt == '0) begin
          fill_valid_next = 1'b1;
          out_valid_next  = 1'b1;
          out_depth_next  = '0;
          out_status_next = ST_FILL;
        end
      end
      S_POP_TOP: begin
        lvl_next = h_rd[HW-1 -: 32];
        cy_next  = h_rd[2*XW-1:XW];
        cx_next  = h_rd[XW-1:0];
        cnt_next = cnt - (AW+1)'(1);
        k_next   = '0;
        h_ra     = AW'(cnt - (AW+1)'(1));
      end
      S_POP_LAST: begin
        ent_next = h_rd;
        p_next   = '0;
      end
      S_SD_L: begin
        if (l_idx >= cnt) begin
          h_we = 1'b1;
        end else begin
          h_ra = l_idx[AW-1:0];
        end
      end
      S_SD_R: begin
        ecl_next   = h_rd;
        has_r_next = r_idx < cnt;
        h_ra       = r_idx[AW-1:0];
      end
      S_SD_CMP: begin
        h_we = 1'b1;
        if (nb_less) begin
          h_wd   = best_d;
          p_next = best_i;
        end
      end
      S_NB_CHK: begin
        nx_next = nx_c;
        ny_next = ny_c;
        ni_next = ni_c;
        v_ra    = ni_c;
        g_ra    = ni_c;
      end
      S_NB_TST: begin
        if (!v_rd) begin
          v_we     = 1'b1;
          v_wa     = ni;
          v_wd     = 1'b1;
          f_we     = 1'b1;
          f_wa     = ni;
          f_wd     = new_lvl;
          ent_next = {new_lvl, ny, nx};
          p_next   = cnt[AW-1:0];
          cnt_next = cnt + (AW+1)'(1);
          ret_next = S_NB_ADV;
        end
      end
      S_NB_ADV: begin
        k_next = k + 3'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      grid_side  <= 9'd256;
      fill_valid <= 1'b0;
      out_valid  <= 1'b0;
      cnt        <= '0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      grid_side  <= grid_side_next;
      fill_valid <= fill_valid_next;
      out_valid  <= out_valid_next;
      cnt        <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    out_depth  <= out_depth_next;
    out_status <= out_status_next;
    addr  <= addr_next;
    x     <= x_next;
    y     <= y_next;
    cx    <= cx_next;
    cy    <= cy_next;
    nx    <= nx_next;
    ny    <= ny_next;
    ni    <= ni_next;
    lvl   <= lvl_next;
    k     <= k_next;
    p     <= p_next;
    par   <= par_next;
    ent   <= ent_next;
    ecl   <= ecl_next;
    has_r <= has_r_next;
  end

`ifndef ASSERT_OFF
  a_heap_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= (AW+1)'(CELLS))
    else $error("heap count beyond capacity");

  a_fill_start: assert property (@(posedge clk) disable iff (rst)
    in_acc && mode == MODE_FILL |=> state == S_SW_RD)
    else $error("fill did not start the sweep");

  a_fill_flag: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) && m_tuser == ST_FILL |-> fill_valid)
    else $error("fill result without valid fill");
`endif

endmodule
